FILE: hdl/ffra_pkg.sv
// Package for the first-fit range allocator: field widths, codes, reset values
// and the table entry and control types. No dependencies.
`timescale 1ns / 1ps

package ffra_pkg;

  // Field widths of the transactions
  localparam int unsigned OFF_W   = 28;  // free_offset, grant_offset
  localparam int unsigned SIZE_W  = 29;  // req_size, free_size, grant_size, registers
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 6;

  // Stored start offsets may run past the chunk after allocations on overlapping
  // ranges, so the table keeps two extra start bits; sums need one more again.
  localparam int unsigned START_W = 30;
  localparam int unsigned ALU_W   = 31;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REMAINDER = 1'd1;

  // Chunk sizes above 2^OFFSET_BITS saturate
  localparam int unsigned OFFSET_BITS = 28;
  localparam logic [63:0] CHUNK_LIMIT = 64'(1) << OFFSET_BITS;

  localparam int unsigned MAX_RANGES_DEF = 32;

  localparam logic [SIZE_W-1:0] CHUNK_RESET  = 29'd67108864;
  localparam logic [SIZE_W-1:0] MINREM_RESET = 29'(4 << 10);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  len;
  } ffra_entry_t;

  // Table write request
  typedef struct packed {
    logic        we;
    ffra_entry_t entry;
  } ffra_wr_t;

  // Table reinitialisation: entry 0 becomes (0, len)
  typedef struct packed {
    logic              init;
    logic [SIZE_W-1:0] len;
  } ffra_init_t;

endpackage

FILE: hdl/ffra_if.sv
// Valid/ready channel interfaces for request and result transactions.
// Depends on ffra_pkg for the field widths.
`timescale 1ns / 1ps

interface ffra_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [ffra_pkg::SIZE_W-1:0] req_size;
  logic [ffra_pkg::OFF_W-1:0]  free_offset;
  logic [ffra_pkg::SIZE_W-1:0] free_size;

  modport source (output valid, output operation, output req_size, output free_offset,
                  output free_size, input ready);
  modport sink   (input valid, input operation, input req_size, input free_offset,
                  input free_size, output ready);
endinterface

interface ffra_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffra_pkg::STAT_W-1:0]  status;
  logic [ffra_pkg::OFF_W-1:0]   grant_offset;
  logic [ffra_pkg::SIZE_W-1:0]  grant_size;
  logic                         chunk_empty;
  logic [ffra_pkg::COUNT_W-1:0] range_count;

  modport source (output valid, output status, output grant_offset, output grant_size,
                  output chunk_empty, output range_count, input ready);
  modport sink   (input valid, input status, input grant_offset, input grant_size,
                  input chunk_empty, input range_count, output ready);
endinterface

FILE: hdl/ffra_alu.sv
// Shared add/subtract unit of the allocator sequencer; bit ALU_W of the result
// is the carry, or the borrow on a subtraction. Depends on ffra_pkg.
`timescale 1ns / 1ps

module ffra_alu (
  input  logic [ffra_pkg::ALU_W-1:0] a_i,
  input  logic [ffra_pkg::ALU_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [ffra_pkg::ALU_W:0]   res_o
);

  always_comb begin
    if (sub_i) begin
      res_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      res_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

endmodule

FILE: hdl/ffra_table.sv
// Free range table: one write and one registered read port, with entry 0 also
// held in flops so that reinitialisation is immediate. Depends on ffra_pkg.
`timescale 1ns / 1ps

module ffra_table #(
  parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_RANGES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output ffra_pkg::ffra_entry_t         rd_entry_o,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  ffra_pkg::ffra_wr_t            wr_i,
  input  ffra_pkg::ffra_init_t          init_i,
  output logic [ffra_pkg::SIZE_W-1:0]   len0_o
);

  ffra_pkg::ffra_entry_t mem_q [MAX_RANGES];
  ffra_pkg::ffra_entry_t rd_q;
  ffra_pkg::ffra_entry_t head_q;
  logic                  sel0_q;

  // Storage array, entries past the fill count are never read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_addr_i] <= wr_i.entry;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Entry 0 copy, carries the reset and reinitialised value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q.start <= '0;
      head_q.len   <= ffra_pkg::CHUNK_RESET;
      sel0_q       <= 1'b0;
    end else begin
      sel0_q <= (rd_addr_i == '0);
      if (init_i.init) begin
        head_q.start <= '0;
        head_q.len   <= init_i.len;
      end else if (wr_i.we && (wr_addr_i == '0)) begin
        head_q <= wr_i.entry;
      end
    end
  end

  assign rd_entry_o = sel0_q ? head_q : rd_q;
  assign len0_o     = head_q.len;

endmodule

FILE: hdl/ffra_ctrl.sv
// Sequencer of the allocator: request capture, table scans and compaction
// through the shared ALU, configuration registers and the result register.
// Depends on ffra_pkg, ffra_if and ffra_alu.
`timescale 1ns / 1ps

module ffra_ctrl #(
  parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_RANGES),
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ffra_in_if.sink                           in_i,
  ffra_out_if.source                        out_o,
  output logic [IDX_W-1:0]                  rd_addr_o,
  input  ffra_pkg::ffra_entry_t             rd_entry_i,
  output logic [IDX_W-1:0]                  wr_addr_o,
  output ffra_pkg::ffra_wr_t                wr_o,
  output ffra_pkg::ffra_init_t              init_o,
  input  logic [ffra_pkg::SIZE_W-1:0]       len0_i
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_SCAN  = 4'd1;
  localparam logic [3:0] S_A_DEC   = 4'd2;
  localparam logic [3:0] S_A_UPD   = 4'd3;
  localparam logic [3:0] S_A_SHIFT = 4'd4;
  localparam logic [3:0] S_F_SUM   = 4'd5;
  localparam logic [3:0] S_F_CHK   = 4'd6;
  localparam logic [3:0] S_F_SCAN  = 4'd7;
  localparam logic [3:0] S_F_LEN   = 4'd8;
  localparam logic [3:0] S_F_FIX   = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0]                    state_q, state_d;
  logic [CNT_W-1:0]              held_q, held_d;
  logic [ffra_pkg::SIZE_W-1:0]   chunk_q, chunk_d;
  logic [ffra_pkg::SIZE_W-1:0]   minrem_q, minrem_d;
  logic [CNT_W-1:0]              ip_q, ip_d;
  logic [CNT_W-1:0]              ep_q, ep_d;
  logic                          dv_q, dv_d;
  logic [CNT_W-1:0]              kept_q, kept_d;
  logic                          merged_q, merged_d;
  logic                          wide_q, wide_d;
  logic                          reject_q, reject_d;
  logic [ffra_pkg::SIZE_W-1:0]   req_q, req_d;
  logic [ffra_pkg::SIZE_W-1:0]   fsize_q, fsize_d;
  logic [ffra_pkg::START_W-1:0]  off_q, off_d;
  logic [ffra_pkg::ALU_W-1:0]    end_q, end_d;
  ffra_pkg::ffra_entry_t         cur_q, cur_d;
  logic [ffra_pkg::SIZE_W-1:0]   left_q, left_d;
  logic [CNT_W-1:0]              idx_q, idx_d;
  logic [ffra_pkg::STAT_W-1:0]   status_q, status_d;
  logic [ffra_pkg::OFF_W-1:0]    goff_q, goff_d;
  logic [ffra_pkg::SIZE_W-1:0]   gsize_q, gsize_d;

  // Result register
  logic                          ovalid_q, ovalid_d;
  logic [ffra_pkg::STAT_W-1:0]   ostatus_q, ostatus_d;
  logic [ffra_pkg::OFF_W-1:0]    ogoff_q, ogoff_d;
  logic [ffra_pkg::SIZE_W-1:0]   ogsize_q, ogsize_d;
  logic                          oempty_q, oempty_d;
  logic [ffra_pkg::COUNT_W-1:0]  ocount_q, ocount_d;

  logic [ffra_pkg::ALU_W-1:0]    alu_a, alu_b;
  logic                          alu_sub;
  logic [ffra_pkg::ALU_W:0]      alu_res;

  logic                          in_acc;
  logic                          issue_ok;
  logic                          stream_done;
  logic                          hit_hi, hit_lo;
  logic                          mask_now;
  logic [ffra_pkg::SIZE_W-1:0]   chunk_sat;
  logic [CNT_W+ffra_pkg::COUNT_W-1:0] held_ext;
  logic [CNT_W-1:0]              ep_dec;

  ffra_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign out_o.valid        = ovalid_q;
  assign out_o.status       = ostatus_q;
  assign out_o.grant_offset = ogoff_q;
  assign out_o.grant_size   = ogsize_q;
  assign out_o.chunk_empty  = oempty_q;
  assign out_o.range_count  = ocount_q;

  // Streaming read pointer: one entry issued per cycle, its data read back in the next cycle
  assign issue_ok    = (ip_q < held_q);
  assign stream_done = !dv_q && !issue_ok;
  assign rd_addr_o   = ip_q[IDX_W-1:0];
  assign ep_dec      = ep_q - ONE_CNT;

  // Free pass merge tests against the region as it stands so far
  assign hit_hi   = ({1'b0, rd_entry_i.start} == end_q);
  assign hit_lo   = (alu_res[ffra_pkg::ALU_W-1:0] == {1'b0, off_q});
  // Until a merge is seen on a full table the free may still fail, so keep raw
  assign mask_now = (held_q != MAX_CNT) || merged_q;

  assign chunk_sat = ({35'd0, cfg_data_i} > ffra_pkg::CHUNK_LIMIT)
                   ? ffra_pkg::CHUNK_LIMIT[ffra_pkg::SIZE_W-1:0] : cfg_data_i;
  assign held_ext  = {{ffra_pkg::COUNT_W{1'b0}}, held_q};

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    chunk_d  = chunk_q;
    minrem_d = minrem_q;
    ip_d     = ip_q;
    ep_d     = ip_q;
    dv_d     = 1'b0;
    kept_d   = kept_q;
    merged_d = merged_q;
    wide_d   = wide_q;
    reject_d = reject_q;
    req_d    = req_q;
    fsize_d  = fsize_q;
    off_d    = off_q;
    end_d    = end_q;
    cur_d    = cur_q;
    left_d   = left_q;
    idx_d    = idx_q;
    status_d = status_q;
    goff_d   = goff_q;
    gsize_d  = gsize_q;

    ovalid_d  = ovalid_q && !out_o.ready;
    ostatus_d = ostatus_q;
    ogoff_d   = ogoff_q;
    ogsize_d  = ogsize_q;
    oempty_d  = oempty_q;
    ocount_d  = ocount_q;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    wr_addr_o   = ip_q[IDX_W-1:0];
    wr_o.we     = 1'b0;
    wr_o.entry  = rd_entry_i;
    init_o.init = 1'b0;
    init_o.len  = chunk_sat;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d    = in_i.req_size;
          fsize_d  = in_i.free_size;
          off_d    = {2'b00, in_i.free_offset};
          status_d = ffra_pkg::STATUS_OK;
          goff_d   = '0;
          gsize_d  = '0;
          ip_d     = '0;
          if (in_i.operation == ffra_pkg::OP_FREE) begin
            state_d = S_F_SUM;
          end else if (in_i.req_size == '0) begin
            status_d = ffra_pkg::STATUS_NOFIT;
            state_d  = S_FIN;
          end else begin
            state_d = S_A_SCAN;
          end
        end
      end

      // First entry long enough
      S_A_SCAN: begin
        dv_d = issue_ok;
        ip_d = issue_ok ? ip_q + ONE_CNT : ip_q;
        alu_a   = {2'b00, rd_entry_i.len};
        alu_b   = {2'b00, req_q};
        alu_sub = 1'b1;
        if (dv_q && !alu_res[ffra_pkg::ALU_W]) begin
          cur_d   = rd_entry_i;
          left_d  = alu_res[ffra_pkg::SIZE_W-1:0];
          idx_d   = ep_q;
          dv_d    = 1'b0;
          state_d = S_A_DEC;
        end else if (stream_done) begin
          status_d = ffra_pkg::STATUS_NOFIT;
          state_d  = S_FIN;
        end
      end

      // Absorb a short leftover or trim the range from its front
      S_A_DEC: begin
        alu_a   = {2'b00, left_q};
        alu_b   = {2'b00, minrem_q};
        alu_sub = 1'b1;
        goff_d  = cur_q.start[ffra_pkg::OFF_W-1:0];
        if ((left_q == '0) || alu_res[ffra_pkg::ALU_W]) begin
          gsize_d = cur_q.len;
          ip_d    = idx_q + ONE_CNT;
          state_d = S_A_SHIFT;
        end else begin
          gsize_d = req_q;
          state_d = S_A_UPD;
        end
      end

      S_A_UPD: begin
        alu_a       = {1'b0, cur_q.start};
        alu_b       = {2'b00, req_q};
        wr_addr_o   = idx_q[IDX_W-1:0];
        wr_o.we     = 1'b1;
        wr_o.entry.start = alu_res[ffra_pkg::START_W-1:0];
        wr_o.entry.len   = left_q;
        state_d     = S_FIN;
      end

      // Move later entries up one place
      S_A_SHIFT: begin
        dv_d = issue_ok;
        ip_d = issue_ok ? ip_q + ONE_CNT : ip_q;
        if (dv_q) begin
          wr_addr_o = ep_dec[IDX_W-1:0];
          wr_o.we   = 1'b1;
        end
        if (stream_done) begin
          held_d  = held_q - ONE_CNT;
          state_d = S_FIN;
        end
      end

      // End of the freed region
      S_F_SUM: begin
        alu_a    = {1'b0, off_q};
        alu_b    = {2'b00, fsize_q};
        end_d    = alu_res[ffra_pkg::ALU_W-1:0];
        reject_d = (fsize_q == '0);
        state_d  = S_F_CHK;
      end

      // Region must be non-empty and lie inside the chunk
      S_F_CHK: begin
        alu_a   = {2'b00, chunk_q};
        alu_b   = end_q;
        alu_sub = 1'b1;
        ip_d     = '0;
        kept_d   = '0;
        merged_d = 1'b0;
        wide_d   = 1'b0;
        if (reject_q || alu_res[ffra_pkg::ALU_W]) begin
          status_d = ffra_pkg::STATUS_NOFIT;
          state_d  = S_FIN;
        end else begin
          state_d = S_F_SCAN;
        end
      end

      // Merge touching ranges, compact the rest in place
      S_F_SCAN: begin
        dv_d  = issue_ok;
        ip_d  = issue_ok ? ip_q + ONE_CNT : ip_q;
        alu_a = {1'b0, rd_entry_i.start};
        alu_b = {2'b00, rd_entry_i.len};
        if (dv_q) begin
          if (hit_hi) begin
            end_d    = alu_res[ffra_pkg::ALU_W-1:0];
            merged_d = 1'b1;
          end else if (hit_lo) begin
            off_d    = rd_entry_i.start;
            merged_d = 1'b1;
          end else begin
            wr_addr_o = kept_q[IDX_W-1:0];
            wr_o.we   = 1'b1;
            if (mask_now) begin
              wr_o.entry.start = {2'b00, rd_entry_i.start[ffra_pkg::OFF_W-1:0]};
            end else if (rd_entry_i.start[ffra_pkg::START_W-1:ffra_pkg::OFF_W] != '0) begin
              wide_d = 1'b1;
            end
            kept_d = kept_q + ONE_CNT;
          end
        end
        if (stream_done) begin
          if (kept_q == MAX_CNT) begin
            status_d = ffra_pkg::STATUS_FULL;
            state_d  = S_FIN;
          end else begin
            state_d = S_F_LEN;
          end
        end
      end

      // Append the merged region
      S_F_LEN: begin
        alu_a            = end_q;
        alu_b            = {1'b0, off_q};
        alu_sub          = 1'b1;
        wr_addr_o        = kept_q[IDX_W-1:0];
        wr_o.we          = 1'b1;
        wr_o.entry.start = {2'b00, off_q[ffra_pkg::OFF_W-1:0]};
        wr_o.entry.len   = alu_res[ffra_pkg::SIZE_W-1:0];
        held_d           = kept_q + ONE_CNT;
        ip_d             = '0;
        state_d          = wide_q ? S_F_FIX : S_FIN;
      end

      // Trim start offsets kept raw before the first merge
      S_F_FIX: begin
        dv_d = issue_ok;
        ip_d = issue_ok ? ip_q + ONE_CNT : ip_q;
        if (dv_q) begin
          wr_addr_o        = ep_q[IDX_W-1:0];
          wr_o.we          = 1'b1;
          wr_o.entry.start = {2'b00, rd_entry_i.start[ffra_pkg::OFF_W-1:0]};
        end
        if (stream_done) begin
          state_d = S_FIN;
        end
      end

      // Load the result once the register is free
      S_FIN: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          ogoff_d   = goff_q;
          ogsize_d  = gsize_q;
          oempty_d  = (held_q == ONE_CNT) && (len0_i == chunk_q);
          ocount_d  = held_ext[ffra_pkg::COUNT_W-1:0];
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register writes, to be issued only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      if (cfg_idx_i == ffra_pkg::CFG_CHUNK_SIZE) begin
        chunk_d     = chunk_sat;
        held_d      = {{(CNT_W-1){1'b0}}, (chunk_sat != '0)};
        init_o.init = 1'b1;
      end else if (cfg_idx_i == ffra_pkg::CFG_MIN_REMAINDER) begin
        minrem_d = cfg_data_i;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      held_q   <= ONE_CNT;
      chunk_q  <= ffra_pkg::CHUNK_RESET;
      minrem_q <= ffra_pkg::MINREM_RESET;
      dv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      chunk_q  <= chunk_d;
      minrem_q <= minrem_d;
      dv_q     <= dv_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    ip_q      <= ip_d;
    ep_q      <= ep_d;
    kept_q    <= kept_d;
    merged_q  <= merged_d;
    wide_q    <= wide_d;
    reject_q  <= reject_d;
    req_q     <= req_d;
    fsize_q   <= fsize_d;
    off_q     <= off_d;
    end_q     <= end_d;
    cur_q     <= cur_d;
    left_q    <= left_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    goff_q    <= goff_d;
    gsize_q   <= gsize_d;
    ostatus_q <= ostatus_d;
    ogoff_q   <= ogoff_d;
    ogsize_q  <= ogsize_d;
    oempty_q  <= oempty_d;
    ocount_q  <= ocount_d;
  end

  // Fill count never passes the table depth
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= MAX_CNT)
    else $error("range count above table depth");

  // Compaction never writes ahead of the entry being read
  a_kept_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_F_SCAN && dv_q) |-> (kept_q <= ep_q))
    else $error("compaction overtook the scan");

  // The shift never writes below entry 0
  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SHIFT && dv_q) |-> (ep_q != '0))
    else $error("shift read entry 0");

  // Table is written only in the states that edit it
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (state_q == S_A_UPD || state_q == S_A_SHIFT || state_q == S_F_SCAN ||
                 state_q == S_F_LEN || state_q == S_F_FIX))
    else $error("table write outside an editing state");

  // A failed transaction grants nothing
  a_fail_nogrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostatus_q != ffra_pkg::STATUS_OK) |-> (ogsize_q == '0 && ogoff_q == '0))
    else $error("grant reported on a failed transaction");

endmodule

FILE: hdl/first_fit_range_allocator.sv
// First-fit range allocator, top level: shared-ALU sequencer and range table; needs ffra_pkg,
//   ffra_if, ffra_ctrl, ffra_table.
// One transaction at a time, the next taken the cycle after the result loads.
// Reset leaves one free range over the default chunk; a chunk_size write does the same at once
// for the new chunk, or leaves no range when the new chunk size is zero.
`timescale 1ns / 1ps

module first_fit_range_allocator #(
  parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffra_in_if.sink                         in_i,
  ffra_out_if.source                      out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);

  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  ffra_pkg::ffra_entry_t       rd_entry;
  ffra_pkg::ffra_wr_t          wr_req;
  ffra_pkg::ffra_init_t        init_req;
  logic [ffra_pkg::SIZE_W-1:0] len0;

  // Sequencer
  ffra_ctrl #(
    .MAX_RANGES (MAX_RANGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .rd_addr_o  (rd_addr),
    .rd_entry_i (rd_entry),
    .wr_addr_o  (wr_addr),
    .wr_o       (wr_req),
    .init_o     (init_req),
    .len0_i     (len0)
  );

  // Range table
  ffra_table #(
    .MAX_RANGES (MAX_RANGES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_addr_i  (wr_addr),
    .wr_i       (wr_req),
    .init_i     (init_req),
    .len0_o     (len0)
  );

endmodule
